// ----- sv/rtpred_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the redundant text payload depacketizer.
// Used by rtpred_ctrl, rtpred_dp and the top level; depends on nothing.
package rtpred_pkg;

    // Default number of redundant block headers held per packet
    localparam int MAX_BLOCKS_DEF = 8;

    // Redundant block header layout: flag, payload type, offset, length
    localparam int PT_BITS     = 7;
    localparam int OFFSET_BITS = 14;
    localparam int LENGTH_BITS = 10;
    localparam int ENTRY_BITS  = OFFSET_BITS + LENGTH_BITS;
    localparam int SHIFT_BITS  = ENTRY_BITS - 8;

    // Packed stream widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 3;

    // Kind of result item to build
    typedef logic [2:0] t_emit_kind;
    localparam t_emit_kind EMIT_BYTE_PRIM = 3'd0;
    localparam t_emit_kind EMIT_BYTE_RED  = 3'd1;
    localparam t_emit_kind EMIT_MARK_RED  = 3'd2;
    localparam t_emit_kind EMIT_MARK_PRIM = 3'd3;
    localparam t_emit_kind EMIT_ERR       = 3'd4;

    typedef struct packed {
        logic       start;        // first byte of a packet: latch and clear
        logic       hdr_byte;     // shift one header byte in
        logic       idx_inc;      // advance to the next block
        logic       bytes_dec;    // count one block byte
        logic       bytes_ld_cur; // load length of the current block
        logic       bytes_ld_nxt; // load length of the following block
        logic       emit;         // write a result item to the output register
        t_emit_kind emit_kind;
        logic       emit_end;
        logic       emit_last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;     // output register can take an item this cycle
        logic hdr_pos_zero; // next header byte starts a header
        logic hdr_full;     // header store holds its maximum
        logic cur_more;     // current block index below header count
        logic cur_len_zero;
        logic nxt_more;     // following block index below header count
        logic nxt_len_zero;
        logic bytes_end;    // at most one byte left in the block
    } t_dp_status;

endpackage

// ----- sv/rtpred_dp.sv -----
`timescale 1ns / 1ps
// Datapath: packet latches, header store, block counters and output register.
// Driven by rtpred_ctrl through rtpred_pkg::t_dp_cmd; uses rtpred_pkg.
module rtpred_dp #(
    parameter int MAX_BLOCKS = rtpred_pkg::MAX_BLOCKS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rtpred_pkg::t_dp_cmd     i_cmd,
    output rtpred_pkg::t_dp_status  o_status,
    input  logic [7:0]              i_data_byte,
    input  logic [31:0]             i_packet_timestamp,
    input  logic [15:0]             i_packet_seq,
    input  logic                    i_packet_mark,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [7:0]              o_out_byte,
    output logic                    o_has_byte,
    output logic [31:0]             o_block_timestamp,
    output logic [15:0]             o_block_seq,
    output logic                    o_block_mark,
    output logic                    o_block_end,
    output logic                    o_block_primary,
    output logic                    o_format_error,
    output logic                    o_last
);

    localparam int CW = $clog2(MAX_BLOCKS + 2);
    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int EW = rtpred_pkg::ENTRY_BITS;
    localparam int LW = rtpred_pkg::LENGTH_BITS;
    localparam int SW = rtpred_pkg::SHIFT_BITS;

    // Header store: offset and length of each redundant block
    logic [EW-1:0] r_hdr_mem [MAX_BLOCKS];
    logic [EW-1:0] r_cur;
    logic [EW-1:0] r_nxt;

    logic [31:0]   r_ts;
    logic [15:0]   r_seq;
    logic          r_mark;
    logic [CW-1:0] r_hdr_count, n_hdr_count;
    logic [1:0]    r_hdr_pos, n_hdr_pos;
    logic [SW-1:0] r_hdr_shift, n_hdr_shift;
    logic [CW-1:0] r_blk_idx, n_blk_idx;
    logic [LW-1:0] r_bytes_left, n_bytes_left;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_has_byte;
    logic [31:0]   r_out_ts;
    logic [15:0]   r_out_seq;
    logic          r_out_mark;
    logic          r_out_end;
    logic          r_out_prim;
    logic          r_out_err;
    logic          r_out_last;

    logic          w_out_free;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_wa;
    logic [EW-1:0] w_mem_wd;
    logic [CW-1:0] w_rd_idx1;
    logic [AW-1:0] w_ra0;
    logic [AW-1:0] w_ra1;
    logic [CW-1:0] w_idx_p1;
    logic [CW-1:0] w_remain;
    logic [31:0]   w_eff_ts;
    logic [15:0]   w_eff_seq;
    logic          w_eff_mark;
    logic [31:0]   w_red_ts;
    logic [15:0]   w_red_seq;
    logic [1:0]    w_pos;
    logic [CW-1:0] w_count;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_idx_p1   = r_blk_idx + CW'(1);
    assign w_remain   = r_hdr_count - r_blk_idx;

    // The first byte of a packet sees its own fields, not the old latches
    assign w_eff_ts   = i_cmd.start ? i_packet_timestamp : r_ts;
    assign w_eff_seq  = i_cmd.start ? i_packet_seq : r_seq;
    assign w_eff_mark = i_cmd.start ? i_packet_mark : r_mark;
    assign w_pos      = i_cmd.start ? 2'd0 : r_hdr_pos;
    assign w_count    = i_cmd.start ? '0 : r_hdr_count;

    assign w_red_ts  = r_ts - 32'(r_cur[EW-1:LW]);
    assign w_red_seq = r_seq - 16'(w_remain);

    always_comb begin
        n_hdr_count  = w_count;
        n_hdr_pos    = w_pos;
        n_hdr_shift  = r_hdr_shift;
        n_blk_idx    = i_cmd.start ? '0 : r_blk_idx;
        n_bytes_left = i_cmd.start ? '0 : r_bytes_left;
        w_mem_we     = 1'b0;
        w_mem_wa     = w_count[AW-1:0];
        w_mem_wd     = {r_hdr_shift, i_data_byte};
        if (i_cmd.hdr_byte) begin
            n_hdr_pos   = w_pos + 2'd1;
            n_hdr_shift = {r_hdr_shift[SW-9:0], i_data_byte};
            if (w_pos == 2'd3) begin
                w_mem_we    = 1'b1;
                n_hdr_count = w_count + CW'(1);
            end
        end
        if (i_cmd.idx_inc) begin
            n_blk_idx = w_idx_p1;
        end
        if (i_cmd.bytes_dec) begin
            n_bytes_left = r_bytes_left - LW'(1);
        end else if (i_cmd.bytes_ld_cur) begin
            n_bytes_left = r_cur[LW-1:0];
        end else if (i_cmd.bytes_ld_nxt) begin
            n_bytes_left = r_nxt[LW-1:0];
        end
    end

    // Read ports follow the next block index so r_cur and r_nxt track it
    assign w_rd_idx1 = n_blk_idx + CW'(1);
    assign w_ra0 = (n_blk_idx < CW'(MAX_BLOCKS)) ? n_blk_idx[AW-1:0] : '0;
    assign w_ra1 = (w_rd_idx1 < CW'(MAX_BLOCKS)) ? w_rd_idx1[AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_hdr_mem[w_mem_wa] <= w_mem_wd;
        end
        r_cur <= r_hdr_mem[w_ra0];
        r_nxt <= r_hdr_mem[w_ra1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_count  <= '0;
            r_hdr_pos    <= '0;
            r_blk_idx    <= '0;
            r_bytes_left <= '0;
        end else begin
            r_hdr_count  <= n_hdr_count;
            r_hdr_pos    <= n_hdr_pos;
            r_blk_idx    <= n_blk_idx;
            r_bytes_left <= n_bytes_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr_shift <= n_hdr_shift;
        if (i_cmd.start) begin
            r_ts   <= i_packet_timestamp;
            r_seq  <= i_packet_seq;
            r_mark <= i_packet_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_mark <= w_eff_mark;
            r_out_last <= i_cmd.emit_last;
            case (i_cmd.emit_kind)
                rtpred_pkg::EMIT_BYTE_PRIM: begin
                    r_out_byte <= i_data_byte;
                    r_has_byte <= 1'b1;
                    r_out_ts   <= w_eff_ts;
                    r_out_seq  <= w_eff_seq;
                    r_out_end  <= i_cmd.emit_end;
                    r_out_prim <= 1'b1;
                    r_out_err  <= 1'b0;
                end
                rtpred_pkg::EMIT_BYTE_RED: begin
                    r_out_byte <= i_data_byte;
                    r_has_byte <= 1'b1;
                    r_out_ts   <= w_red_ts;
                    r_out_seq  <= w_red_seq;
                    r_out_end  <= i_cmd.emit_end;
                    r_out_prim <= 1'b0;
                    r_out_err  <= 1'b0;
                end
                rtpred_pkg::EMIT_MARK_RED: begin
                    r_out_byte <= '0;
                    r_has_byte <= 1'b0;
                    r_out_ts   <= w_red_ts;
                    r_out_seq  <= w_red_seq;
                    r_out_end  <= 1'b1;
                    r_out_prim <= 1'b0;
                    r_out_err  <= 1'b0;
                end
                rtpred_pkg::EMIT_MARK_PRIM: begin
                    r_out_byte <= '0;
                    r_has_byte <= 1'b0;
                    r_out_ts   <= w_eff_ts;
                    r_out_seq  <= w_eff_seq;
                    r_out_end  <= 1'b1;
                    r_out_prim <= 1'b1;
                    r_out_err  <= 1'b0;
                end
                default: begin
                    r_out_byte <= '0;
                    r_has_byte <= 1'b0;
                    r_out_ts   <= w_eff_ts;
                    r_out_seq  <= w_eff_seq;
                    r_out_end  <= 1'b1;
                    r_out_prim <= 1'b1;
                    r_out_err  <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_status.out_free     = w_out_free;
        o_status.hdr_pos_zero = (r_hdr_pos == 2'd0);
        o_status.hdr_full     = (r_hdr_count >= CW'(MAX_BLOCKS));
        o_status.cur_more     = (r_blk_idx < r_hdr_count);
        o_status.cur_len_zero = (r_cur[LW-1:0] == '0);
        o_status.nxt_more     = (w_idx_p1 < r_hdr_count);
        o_status.nxt_len_zero = (r_nxt[LW-1:0] == '0);
        o_status.bytes_end    = (r_bytes_left <= LW'(1));
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_byte        = r_out_byte;
    assign o_has_byte        = r_has_byte;
    assign o_block_timestamp = r_out_ts;
    assign o_block_seq       = r_out_seq;
    assign o_block_mark      = r_out_mark;
    assign o_block_end       = r_out_end;
    assign o_block_primary   = r_out_prim;
    assign o_format_error    = r_out_err;
    assign o_last            = r_out_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_count <= CW'(MAX_BLOCKS))
        else $error("header count above store depth");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blk_idx <= r_hdr_count)
        else $error("block index past header count");
`endif

endmodule

// ----- sv/rtpred_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: packet parse phase, per-item sequencing and the mode register.
// Commands rtpred_dp through rtpred_pkg::t_dp_cmd; uses rtpred_pkg.
module rtpred_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [1:0]              i_cfg_wr_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_flag,
    input  logic                    i_byte_last,
    input  logic [1:0]              i_packet_kind,
    input  rtpred_pkg::t_dp_status  i_status,
    output rtpred_pkg::t_dp_cmd     o_cmd
);

    localparam logic [1:0] S_IN  = 2'd0;
    localparam logic [1:0] S_ADV = 2'd1;
    localparam logic [1:0] S_FIN = 2'd2;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PLAIN = 3'd1;
    localparam logic [2:0] PH_HDR   = 3'd2;
    localparam logic [2:0] PH_RED   = 3'd3;
    localparam logic [2:0] PH_PRIM  = 3'd4;
    localparam logic [2:0] PH_DROP  = 3'd5;

    localparam logic [1:0] MODE_PLAIN = 2'd1;
    localparam logic [1:0] MODE_RED   = 2'd2;
    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_RED   = 2'd1;

    logic [1:0] r_state, n_state;
    logic [2:0] r_phase, n_phase;
    logic       r_lastb, n_lastb;
    logic [1:0] r_codec_mode;

    logic       w_fire;
    logic       w_start;
    logic       w_drop;
    logic [2:0] w_eff_phase;
    logic       w_pos_zero;
    logic       w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec_mode <= '0;
        end else if (i_cfg_wr_en) begin
            r_codec_mode <= i_cfg_wr_data;
        end
    end

    assign o_in_ready = (r_state == S_IN) && i_status.out_free;
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_start    = (r_phase == PH_IDLE);
    assign w_drop     = !((r_codec_mode == MODE_PLAIN) || (r_codec_mode == MODE_RED))
                     || !((i_packet_kind == KIND_PLAIN) || (i_packet_kind == KIND_RED));
    assign w_eff_phase = !w_start ? r_phase
                       : w_drop ? PH_DROP
                       : (i_packet_kind == KIND_PLAIN) ? PH_PLAIN : PH_HDR;
    assign w_pos_zero = w_start || i_status.hdr_pos_zero;
    assign w_full     = !w_start && i_status.hdr_full;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_lastb = r_lastb;
        o_cmd   = '0;
        unique case (r_state)
            S_IN: begin
                if (w_fire) begin
                    o_cmd.start = w_start;
                    n_phase     = w_eff_phase;
                    n_lastb     = i_byte_last;
                    case (w_eff_phase)
                        PH_PLAIN, PH_PRIM: begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_kind = rtpred_pkg::EMIT_BYTE_PRIM;
                            o_cmd.emit_end  = i_byte_last;
                            o_cmd.emit_last = 1'b1;
                        end
                        PH_HDR: begin
                            if (w_pos_zero && !i_flag) begin
                                // primary header: walk the blocks next cycle
                                n_state = S_ADV;
                            end else if (w_pos_zero && w_full) begin
                                o_cmd.emit      = 1'b1;
                                o_cmd.emit_kind = rtpred_pkg::EMIT_ERR;
                                o_cmd.emit_last = 1'b1;
                                n_phase         = PH_DROP;
                            end else begin
                                o_cmd.hdr_byte  = 1'b1;
                                o_cmd.emit      = i_byte_last;
                                o_cmd.emit_kind = rtpred_pkg::EMIT_ERR;
                                o_cmd.emit_last = 1'b1;
                            end
                        end
                        PH_RED: begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_kind = rtpred_pkg::EMIT_BYTE_RED;
                            o_cmd.emit_end  = i_status.bytes_end;
                            o_cmd.emit_last = !i_byte_last;
                            if (!i_status.bytes_end) begin
                                o_cmd.bytes_dec = 1'b1;
                            end else begin
                                o_cmd.idx_inc = 1'b1;
                                if (i_status.nxt_more && i_status.nxt_len_zero) begin
                                    // empty blocks follow: emit their markers next
                                    o_cmd.emit_last = 1'b0;
                                    n_state         = S_ADV;
                                end else if (i_status.nxt_more) begin
                                    o_cmd.bytes_ld_nxt = 1'b1;
                                end else begin
                                    n_phase = PH_PRIM;
                                end
                            end
                            if (i_byte_last && (n_state == S_IN)) begin
                                n_state = S_FIN;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (i_byte_last && (n_state == S_IN)) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            S_ADV: begin
                if (i_status.cur_more && !i_status.cur_len_zero) begin
                    o_cmd.bytes_ld_cur = 1'b1;
                    n_phase            = PH_RED;
                    n_state            = r_lastb ? S_FIN : S_IN;
                end else if (i_status.cur_more) begin
                    // hold until the output register frees up
                    if (i_status.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = rtpred_pkg::EMIT_MARK_RED;
                        o_cmd.emit_end  = 1'b1;
                        o_cmd.emit_last = !(r_lastb ||
                                            (i_status.nxt_more && i_status.nxt_len_zero));
                        o_cmd.idx_inc   = 1'b1;
                    end
                end else begin
                    n_phase = PH_PRIM;
                    n_state = r_lastb ? S_FIN : S_IN;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = (r_phase == PH_PRIM) ? rtpred_pkg::EMIT_MARK_PRIM
                                                           : rtpred_pkg::EMIT_ERR;
                    o_cmd.emit_end  = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_phase         = PH_IDLE;
                    n_state         = S_IN;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_phase <= PH_IDLE;
            r_lastb <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_lastb <= n_lastb;
        end
    end

`ifndef SYNTHESIS
    a_fin_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> ((r_phase == PH_RED) || (r_phase == PH_PRIM)))
        else $error("end marker pending outside the block section");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && !o_cmd.emit_last) |=> (r_state != S_IN))
        else $error("result flagged not last but no further result pending");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("result written over an unaccepted one");
`endif

endmodule

// ----- sv/red_text_payload_depacketizer_top.sv -----
`timescale 1ns / 1ps
// Redundant text payload depacketizer: one payload byte in, zero or more
// result items out. Input bytes are taken one per cycle while the output
// register is free. Extra cycles come from the block walk, which reads the
// header store (two registered read ports) one block per cycle, markers
// waiting on a free output register. The walk starts after the primary
// header byte, and after a redundant byte that ends its block when an empty
// block follows; it emits a marker per empty block, then loads the next
// block with bytes or enters the primary block. A redundant packet whose last
// byte is the primary header or falls inside a redundant block takes an extra
// S_FIN step for its end marker. A result waits in a single output register;
// the next byte is taken in the cycle that result is taken; a stalled result
// blocks input and results. codec_mode is sampled on each packet's first byte.
module red_text_payload_depacketizer_top #(
    parameter int MAX_BLOCKS = rtpred_pkg::MAX_BLOCKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [1:0]                       i_cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // data_byte[7:0], packet_timestamp[39:8], packet_seq[55:40], packet_mark[56]
    input  logic [rtpred_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                             s_axis_tlast,   // byte_last
    // packet_kind[1:0]
    input  logic [rtpred_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_byte[7:0], block_timestamp[39:8], block_seq[55:40], block_mark[56],
    // block_end[57]
    output logic [rtpred_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast,   // last
    // has_byte[0], block_primary[1], format_error[2]
    output logic [rtpred_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    rtpred_pkg::t_dp_cmd    w_cmd;
    rtpred_pkg::t_dp_status w_status;

    logic [7:0]  w_out_byte;
    logic        w_has_byte;
    logic [31:0] w_block_ts;
    logic [15:0] w_block_seq;
    logic        w_block_mark;
    logic        w_block_end;
    logic        w_block_prim;
    logic        w_format_err;

    rtpred_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_flag        (s_axis_tdata[rtpred_pkg::PT_BITS]),
        .i_byte_last   (s_axis_tlast),
        .i_packet_kind (s_axis_tuser[1:0]),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    rtpred_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_data_byte        (s_axis_tdata[7:0]),
        .i_packet_timestamp (s_axis_tdata[39:8]),
        .i_packet_seq       (s_axis_tdata[55:40]),
        .i_packet_mark      (s_axis_tdata[56]),
        .i_out_ready        (m_axis_tready),
        .o_out_valid        (m_axis_tvalid),
        .o_out_byte         (w_out_byte),
        .o_has_byte         (w_has_byte),
        .o_block_timestamp  (w_block_ts),
        .o_block_seq        (w_block_seq),
        .o_block_mark       (w_block_mark),
        .o_block_end        (w_block_end),
        .o_block_primary    (w_block_prim),
        .o_format_error     (w_format_err),
        .o_last             (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, w_block_end, w_block_mark, w_block_seq,
                           w_block_ts, w_out_byte};
    assign m_axis_tuser = {w_format_err, w_block_prim, w_has_byte};

endmodule
